// ===== rtl/rgbled_pkg.sv =====
// Shared types and constants for the RGB status LED sequencer.
// No dependencies; imported by every module of the block.
package rgbled_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ITEM_W      = 40;
    localparam int COLOUR_W    = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOW_BATTERY_MV     = 3'd0,
        REG_BOOT_SWEEP_MS      = 3'd1,
        REG_MESSAGE_SWEEP_MS   = 3'd2,
        REG_BLINK_ON_MS        = 3'd3,
        REG_BLINK_ON_UNREAD_MS = 3'd4,
        REG_BLINK_CYCLE_MS     = 3'd5,
        REG_BATTERY_CHECK_MS   = 3'd6,
        REG_CHARGE_DISPLAY_EN  = 3'd7
    } cfg_index_t;

    localparam logic [15:0] RST_LOW_BATTERY_MV     = 16'd3500;
    localparam logic [15:0] RST_BOOT_SWEEP_MS      = 16'd1200;
    localparam logic [15:0] RST_MESSAGE_SWEEP_MS   = 16'd800;
    localparam logic [15:0] RST_BLINK_ON_MS        = 16'd20;
    localparam logic [15:0] RST_BLINK_ON_UNREAD_MS = 16'd200;
    localparam logic [15:0] RST_BLINK_CYCLE_MS     = 16'd4000;
    localparam logic [15:0] RST_BATTERY_CHECK_MS   = 16'd60000;

    // hue wheel and breathing periods
    localparam logic [10:0] WHEEL_LAST   = 11'd1199;
    localparam logic [10:0] BREATH_LAST  = 11'd1999;
    localparam logic [10:0] BREATH_HALF  = 11'd1000;
    localparam logic [10:0] BREATH_FULL  = 11'd2000;
    localparam logic [7:0]  WHEEL_THIRD  = 8'd85;
    localparam logic [7:0]  WHEEL_2THIRD = 8'd170;

    // reciprocal multipliers: /5 (wide), /125, /5 (narrow)
    localparam logic [24:0] RECIP_5_WIDE = 25'd13108;
    localparam logic [30:0] RECIP_125    = 31'd33555;
    localparam logic [17:0] RECIP_5      = 18'd205;

    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] AMBER_G    = 8'd90;
    localparam logic [7:0] DIM_G      = 8'd40;

    typedef struct packed {
        logic [15:0] low_battery_mv;
        logic [15:0] boot_sweep_ms;
        logic [15:0] message_sweep_ms;
        logic [15:0] blink_on_ms;
        logic [15:0] blink_on_unread_ms;
        logic [15:0] blink_cycle_ms;
        logic [15:0] battery_check_ms;
        logic        charge_display_enable;
    } cfg_t;

    typedef struct packed {
        logic        charge_pin_low;
        logic        external_power;
        logic [15:0] battery_mv;
        logic        app_connected;
        logic [15:0] unread_count;
    } item_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } colour_t;

    typedef struct packed {
        logic load_item;
        logic step_b;
        logic step_c;
        logic commit;
    } cmd_t;

endpackage

// ===== rtl/rgbled_cfg_regs.sv =====
// Configuration register file for the RGB status LED sequencer.
// Depends on rgbled_pkg.
module rgbled_cfg_regs
    import rgbled_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_battery_mv        <= RST_LOW_BATTERY_MV;
            cfg_reg.boot_sweep_ms         <= RST_BOOT_SWEEP_MS;
            cfg_reg.message_sweep_ms      <= RST_MESSAGE_SWEEP_MS;
            cfg_reg.blink_on_ms           <= RST_BLINK_ON_MS;
            cfg_reg.blink_on_unread_ms    <= RST_BLINK_ON_UNREAD_MS;
            cfg_reg.blink_cycle_ms        <= RST_BLINK_CYCLE_MS;
            cfg_reg.battery_check_ms      <= RST_BATTERY_CHECK_MS;
            cfg_reg.charge_display_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_LOW_BATTERY_MV:     cfg_reg.low_battery_mv     <= wr_data;
                REG_BOOT_SWEEP_MS:      cfg_reg.boot_sweep_ms      <= wr_data;
                REG_MESSAGE_SWEEP_MS:   cfg_reg.message_sweep_ms   <= wr_data;
                REG_BLINK_ON_MS:        cfg_reg.blink_on_ms        <= wr_data;
                REG_BLINK_ON_UNREAD_MS: cfg_reg.blink_on_unread_ms <= wr_data;
                REG_BLINK_CYCLE_MS:     cfg_reg.blink_cycle_ms     <= wr_data;
                REG_BATTERY_CHECK_MS:   cfg_reg.battery_check_ms   <= wr_data;
                REG_CHARGE_DISPLAY_EN:  cfg_reg.charge_display_enable <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rgbled_ctrl.sv =====
// Sequencing controller: item handshake, step commands, output valid.
// Depends on rgbled_pkg.
module rgbled_ctrl
    import rgbled_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_B,
        ST_C,
        ST_D
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.load_item = (state_reg == ST_IDLE) && in_valid;
        cmd.step_b    = (state_reg == ST_B);
        cmd.step_c    = (state_reg == ST_C);
        cmd.commit    = (state_reg == ST_D) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_B;
                    end
                end
                ST_B:    state_reg <= ST_C;
                ST_C:    state_reg <= ST_D;
                ST_D:
                begin
                    if (cmd.commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/rgbled_datapath.sv =====
// Datapath: tick time, sweep/heartbeat/charge state, colour arithmetic.
// Depends on rgbled_pkg; driven by rgbled_ctrl commands.
module rgbled_datapath
    import rgbled_pkg::*;
#(
    parameter int TIME_WIDTH      = 32,
    parameter int POWER_SAMPLE_MS = 1000
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  cfg_t    cfg,
    input  item_t   item,
    output colour_t colour
);

    localparam logic [TIME_WIDTH-1:0] POWER_STEP = TIME_WIDTH'(POWER_SAMPLE_MS);

    // item and arithmetic pipeline registers
    item_t       item_reg;
    logic [14:0] wh17_reg;
    logic [14:0] breath_z_reg;
    logic [7:0]  wheel_pos_reg;
    logic [7:0]  lvl_reg;
    logic [8:0]  gq_reg;
    colour_t     wheel_rgb_reg;

    // tick state
    logic [TIME_WIDTH-1:0] tick_time_reg;
    logic [10:0]           wheel_ph_reg;
    logic [10:0]           breath_ph_reg;
    logic                  boot_done_reg;
    logic                  sweep_active_reg;
    logic [TIME_WIDTH-1:0] sweep_end_reg;
    logic [15:0]           previous_unread_reg;
    logic                  blink_lit_reg;
    logic [TIME_WIDTH-1:0] next_toggle_reg;
    logic [15:0]           lit_length_reg;
    logic [TIME_WIDTH-1:0] next_battery_sample_reg;
    logic                  battery_low_reg;
    logic [TIME_WIDTH-1:0] next_power_sample_reg;
    logic                  on_external_reg;
    logic                  charging_now_reg;
    colour_t               held_colour_reg;

    logic                  sweep_active_next;
    logic [TIME_WIDTH-1:0] sweep_end_next;
    logic                  blink_lit_next;
    logic [TIME_WIDTH-1:0] next_toggle_next;
    logic [15:0]           lit_length_next;
    logic [TIME_WIDTH-1:0] next_battery_sample_next;
    logic                  battery_low_next;
    logic [TIME_WIDTH-1:0] next_power_sample_next;
    logic                  on_external_next;
    logic                  charging_now_next;
    colour_t               held_colour_next;

    logic [9:0]  breath_v;
    logic [7:0]  amber_g;
    logic        unread_nz;
    logic        charge_show;
    logic [TIME_WIDTH-1:0] t;

    assign t = tick_time_reg;

    always_comb
    begin
        breath_v = (breath_ph_reg < BREATH_HALF) ? 10'(breath_ph_reg)
                                                 : 10'(BREATH_FULL - breath_ph_reg);
        amber_g  = 8'((18'(gq_reg) * RECIP_5) >> 10);
    end

    // arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg     <= item;
            wh17_reg     <= 15'(wheel_ph_reg) * 15'd17;
            breath_z_reg <= 15'((18'(breath_v) * 18'd255) >> 3);
        end
        if (cmd.step_b)
        begin
            wheel_pos_reg <= 8'((25'(wh17_reg >> 4) * RECIP_5_WIDE) >> 16);
            lvl_reg       <= 8'((31'(breath_z_reg) * RECIP_125) >> 22);
        end
        if (cmd.step_c)
        begin
            gq_reg <= 9'((11'(lvl_reg) * 11'd7) >> 2);
            if (wheel_pos_reg < WHEEL_THIRD)
            begin
                wheel_rgb_reg.red   <= 8'(LEVEL_FULL - 8'(wheel_pos_reg * 8'd3));
                wheel_rgb_reg.green <= 8'(wheel_pos_reg * 8'd3);
                wheel_rgb_reg.blue  <= 8'd0;
            end
            else if (wheel_pos_reg < WHEEL_2THIRD)
            begin
                wheel_rgb_reg.red   <= 8'd0;
                wheel_rgb_reg.green <= 8'(LEVEL_FULL - 8'((wheel_pos_reg - WHEEL_THIRD) * 8'd3));
                wheel_rgb_reg.blue  <= 8'((wheel_pos_reg - WHEEL_THIRD) * 8'd3);
            end
            else
            begin
                wheel_rgb_reg.red   <= 8'((wheel_pos_reg - WHEEL_2THIRD) * 8'd3);
                wheel_rgb_reg.green <= 8'd0;
                wheel_rgb_reg.blue  <= 8'(LEVEL_FULL - 8'((wheel_pos_reg - WHEEL_2THIRD) * 8'd3));
            end
        end
    end

    // decision for one tick
    always_comb
    begin
        sweep_active_next        = sweep_active_reg;
        sweep_end_next           = sweep_end_reg;
        blink_lit_next           = blink_lit_reg;
        next_toggle_next         = next_toggle_reg;
        lit_length_next          = lit_length_reg;
        next_battery_sample_next = next_battery_sample_reg;
        battery_low_next         = battery_low_reg;
        next_power_sample_next   = next_power_sample_reg;
        on_external_next         = on_external_reg;
        charging_now_next        = charging_now_reg;
        held_colour_next         = held_colour_reg;
        unread_nz                = (item_reg.unread_count != 16'd0);
        charge_show              = 1'b0;

        if (!boot_done_reg)
        begin
            sweep_active_next = 1'b1;
            sweep_end_next    = t + TIME_WIDTH'(cfg.boot_sweep_ms);
        end
        if (item_reg.unread_count > previous_unread_reg)
        begin
            sweep_active_next = 1'b1;
            sweep_end_next    = t + TIME_WIDTH'(cfg.message_sweep_ms);
        end

        if (sweep_active_next && (t < sweep_end_next))
        begin
            held_colour_next = wheel_rgb_reg;
        end
        else
        begin
            if (sweep_active_next)
            begin
                held_colour_next  = '0;
                sweep_active_next = 1'b0;
                blink_lit_next    = 1'b0;
                next_toggle_next  = t;
            end

            if (t > next_battery_sample_reg)
            begin
                battery_low_next         = item_reg.battery_mv < cfg.low_battery_mv;
                next_battery_sample_next = t + TIME_WIDTH'(cfg.battery_check_ms);
            end

            if (t > next_power_sample_reg)
            begin
                on_external_next       = item_reg.external_power;
                charging_now_next      = item_reg.external_power & item_reg.charge_pin_low;
                next_power_sample_next = t + POWER_STEP;
            end

            charge_show = cfg.charge_display_enable && on_external_next && !unread_nz;

            if (charge_show)
            begin
                if (charging_now_next)
                begin
                    held_colour_next.red   = lvl_reg;
                    held_colour_next.green = amber_g;
                    held_colour_next.blue  = 8'd0;
                end
                else
                begin
                    held_colour_next.red   = 8'd0;
                    held_colour_next.green = DIM_G;
                    held_colour_next.blue  = 8'd0;
                end
                blink_lit_next   = 1'b0;
                next_toggle_next = t;
            end
            else if (t > next_toggle_next)
            begin
                if (!blink_lit_next)
                begin
                    blink_lit_next   = 1'b1;
                    lit_length_next  = unread_nz ? cfg.blink_on_unread_ms : cfg.blink_on_ms;
                    next_toggle_next = t + TIME_WIDTH'(lit_length_next);
                    if (battery_low_next)
                        held_colour_next = '{blue: 8'd0, green: 8'd0, red: LEVEL_FULL};
                    else if (unread_nz)
                        held_colour_next = '{blue: 8'd0, green: AMBER_G, red: LEVEL_FULL};
                    else if (item_reg.app_connected)
                        held_colour_next = '{blue: LEVEL_FULL, green: 8'd0, red: 8'd0};
                    else
                        held_colour_next = '{blue: 8'd0, green: LEVEL_FULL, red: 8'd0};
                end
                else
                begin
                    blink_lit_next   = 1'b0;
                    next_toggle_next = t + TIME_WIDTH'(cfg.blink_cycle_ms)
                                         - TIME_WIDTH'(lit_length_reg);
                    held_colour_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg           <= '0;
            wheel_ph_reg            <= '0;
            breath_ph_reg           <= '0;
            boot_done_reg           <= 1'b0;
            sweep_active_reg        <= 1'b0;
            sweep_end_reg           <= '0;
            previous_unread_reg     <= '0;
            blink_lit_reg           <= 1'b0;
            next_toggle_reg         <= '0;
            lit_length_reg          <= '0;
            next_battery_sample_reg <= '0;
            battery_low_reg         <= 1'b0;
            next_power_sample_reg   <= '0;
            on_external_reg         <= 1'b0;
            charging_now_reg        <= 1'b0;
            held_colour_reg         <= '0;
        end
        else if (cmd.commit)
        begin
            tick_time_reg <= t + 1'b1;
            // phases restart whenever the time counter wraps to zero
            if (&t)
            begin
                wheel_ph_reg  <= '0;
                breath_ph_reg <= '0;
            end
            else
            begin
                wheel_ph_reg  <= (wheel_ph_reg == WHEEL_LAST) ? '0 : wheel_ph_reg + 11'd1;
                breath_ph_reg <= (breath_ph_reg == BREATH_LAST) ? '0 : breath_ph_reg + 11'd1;
            end
            boot_done_reg           <= 1'b1;
            sweep_active_reg        <= sweep_active_next;
            sweep_end_reg           <= sweep_end_next;
            previous_unread_reg     <= item_reg.unread_count;
            blink_lit_reg           <= blink_lit_next;
            next_toggle_reg         <= next_toggle_next;
            lit_length_reg          <= lit_length_next;
            next_battery_sample_reg <= next_battery_sample_next;
            battery_low_reg         <= battery_low_next;
            next_power_sample_reg   <= next_power_sample_next;
            on_external_reg         <= on_external_next;
            charging_now_reg        <= charging_now_next;
            held_colour_reg         <= held_colour_next;
        end
    end

    assign colour = held_colour_reg;

endmodule

// ===== rtl/rgb_status_led_sequencer.sv =====
// RGB status LED sequencer: one tick transaction in, one colour transaction out.
// m_axis_tvalid is registered by the commit in state D, after states B and C; one
// item at a time passes the four-step sequence through the reciprocal multipliers.
// An input may be taken while the previous colour still waits on m_axis_tready.
// Reset (rst_n low, asynchronous): LED dark, time zero, registers at defaults,
// boot sweep starts on the first tick.
module rgb_status_led_sequencer
    import rgbled_pkg::*;
#(
    parameter int TIME_WIDTH      = 32,
    parameter int POWER_SAMPLE_MS = 1000
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // unread_count[15:0], app_connected[16], battery_mv[32:17],
    // external_power[33], charge_pin_low[34], zero[39:35]
    input  logic [ITEM_W-1:0]      s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red_level[7:0], green_level[15:8], blue_level[23:16]
    output logic [COLOUR_W-1:0]    m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t    cmd;
    cfg_t    cfg;
    item_t   item;
    colour_t colour;

    assign cfg_ready = 1'b1;
    assign item      = item_t'(s_axis_tdata[$bits(item_t)-1:0]);

    rgbled_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rgbled_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    rgbled_datapath #(
        .TIME_WIDTH      (TIME_WIDTH),
        .POWER_SAMPLE_MS (POWER_SAMPLE_MS)
    ) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .item   (item),
        .colour (colour)
    );

    assign m_axis_tdata = colour;

endmodule

// ===== rtl/rgbled_checker.sv =====
// Port-level checks for rgb_status_led_sequencer, attached by bind.
// Depends on rgbled_pkg for port widths.
module rgbled_checker
    import rgbled_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [COLOUR_W-1:0] m_axis_tdata,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight: busy right after an input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while item in flight");

    // a new result frees the input side in the same cycle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown without returning to idle");

    // input side only goes busy through a transaction
    a_busy_needs_transaction: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input went busy without a transaction");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind rgb_status_led_sequencer rgbled_checker u_rgbled_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
